// ===== hdl/nnmm_pkg.sv =====
`timescale 1ns / 1ps
package nnmm_pkg;
	localparam int FeatW = 16;
	localparam int ScoreW = 41;
	localparam int NormW = 40;
	localparam int ProdW = 82;
	localparam int RootW = 42;
	localparam int IdxW = 10;
	localparam int ModeW = 2;
	localparam logic [ModeW-1:0] MODE_MAN = 2'd0;
	localparam logic [ModeW-1:0] MODE_EUC = 2'd1;
	localparam logic [ModeW-1:0] MODE_COS = 2'd2;
	localparam logic [ScoreW-1:0] MAX_SCORE = {1'b0, {(ScoreW-1){1'b1}}};

	typedef struct packed {
		logic signed [ScoreW-1:0] accum;
		logic [NormW-1:0] qnorm;
		logic [NormW-1:0] rnorm;
		logic [ModeW-1:0] mode;
		logic last_row;
	} row_job_t;
endpackage

// ===== hdl/nearest_neighbor_multi_metric.sv =====
`timescale 1ns / 1ps
// Nearest neighbor search: stream the query vector, then candidate rows, one
// element per cycle; each row end yields one item with its score and the best
// row so far. Elements are taken one per cycle, except that input pauses after
// each row end while the finished row moves into a one-entry queue. Distance
// modes go straight to the compare; for cosine the back end first runs the
// four-step multiply, the bit-serial square root and the divider. Input stalls
// while a queued row waits for the back end.
module nearest_neighbor_multi_metric #(
	parameter int VECTOR_LEN = 64,
	parameter int MAX_ROWS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] feature_value,
	input  logic is_query,
	input  logic last_element,
	input  logic last_row,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [40:0] score,
	output logic [9:0] row_index,
	output logic [9:0] best_index,
	output logic is_final
);
	logic [nnmm_pkg::ModeW-1:0] mode_q;
	logic job_valid, job_ready, restart;
	nnmm_pkg::row_job_t job;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? 32'(mode_q) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nnmm_pkg::MODE_MAN;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			mode_q <= pwdata[1:0];
		end
	end

	nnmm_front #(.VECTOR_LEN(VECTOR_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .mode(mode_q), .in_valid(in_valid),
		.in_ready(in_ready), .feature_value(feature_value), .is_query(is_query),
		.last_element(last_element), .last_row(last_row), .job_valid(job_valid),
		.job_ready(job_ready), .job(job), .restart(restart)
	);

	nnmm_back #(.MAX_ROWS(MAX_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .restart(restart), .out_valid(out_valid), .out_ready(out_ready),
		.score(score), .row_index(row_index), .best_index(best_index),
		.is_final(is_final)
	);
endmodule

// ===== hdl/nnmm_ram.sv =====
`timescale 1ns / 1ps
module nnmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/nnmm_front.sv =====
`timescale 1ns / 1ps
module nnmm_front #(
	parameter int VECTOR_LEN = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [nnmm_pkg::ModeW-1:0] mode,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [nnmm_pkg::FeatW-1:0] feature_value,
	input  logic is_query,
	input  logic last_element,
	input  logic last_row,
	output logic job_valid,
	input  logic job_ready,
	output nnmm_pkg::row_job_t job,
	output logic restart
);
	localparam int AW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;

	logic [AW-1:0] count_q;
	logic [nnmm_pkg::NormW-1:0] qnorm_q;
	logic signed [nnmm_pkg::ScoreW-1:0] accum_q;
	logic [nnmm_pkg::NormW-1:0] rnorm_q;
	logic accept, vec_end;
	logic [nnmm_pkg::FeatW-1:0] qraw;

	// Stage 1 registers: element after memory read.
	logic v_s1, q_s1, end_s1, lrow_s1, first_s1;
	logic signed [nnmm_pkg::FeatW-1:0] val_s1;
	logic [nnmm_pkg::ModeW-1:0] mode_s1;

	logic signed [nnmm_pkg::FeatW:0] diff;
	logic [nnmm_pkg::NormW-1:0] vsq, dsq;
	logic signed [nnmm_pkg::ScoreW-1:0] term, base_acc;
	logic [nnmm_pkg::NormW-1:0] base_rn, base_qn;
	logic signed [31:0] xv;
	logic row_end_s1;
	logic job_pend_q;
	nnmm_pkg::row_job_t job_data_q;

	// A finished row goes into a one-entry queue; the stage behind it never stalls.
	assign row_end_s1 = v_s1 && !q_s1 && end_s1;
	assign in_ready = !row_end_s1 && (!job_pend_q || job_ready);
	assign accept = in_valid && in_ready;
	assign vec_end = last_element || (32'(count_q) >= 32'(VECTOR_LEN - 1));

	nnmm_ram #(.WIDTH(nnmm_pkg::FeatW), .DEPTH(VECTOR_LEN)) u_qram (
		.clk(clk), .we(accept && is_query), .waddr(count_q), .wdata(feature_value),
		.raddr(count_q), .rdata(qraw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= vec_end ? '0 : count_q + AW'(1);
			end
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_s1 <= is_query;
			end_s1 <= vec_end;
			lrow_s1 <= last_row;
			first_s1 <= (count_q == '0);
			val_s1 <= feature_value;
			mode_s1 <= mode;
		end
	end

	assign diff = (nnmm_pkg::FeatW+1)'(signed'(qraw)) - (nnmm_pkg::FeatW+1)'(val_s1);
	assign xv = 32'(signed'(qraw)) * 32'(val_s1);
	assign vsq = nnmm_pkg::NormW'(32'(val_s1) * 32'(val_s1));
	assign dsq = nnmm_pkg::NormW'(33'(diff) * 33'(diff));
	assign base_acc = first_s1 ? '0 : accum_q;
	assign base_rn = first_s1 ? '0 : rnorm_q;
	assign base_qn = first_s1 ? '0 : qnorm_q;

	always_comb begin
		case (mode_s1)
			nnmm_pkg::MODE_EUC: term = nnmm_pkg::ScoreW'(dsq);
			nnmm_pkg::MODE_COS: term = nnmm_pkg::ScoreW'(xv);
			default: term = diff[nnmm_pkg::FeatW] ? -nnmm_pkg::ScoreW'(diff)
				: nnmm_pkg::ScoreW'(diff);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qnorm_q <= '0;
			accum_q <= '0;
			rnorm_q <= '0;
		end else if (v_s1) begin
			if (q_s1) begin
				qnorm_q <= base_qn + vsq;
			end else begin
				accum_q <= base_acc + term;
				rnorm_q <= base_rn + vsq;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_pend_q <= 1'b0;
		end else if (row_end_s1) begin
			job_pend_q <= 1'b1;
		end else if (job_ready) begin
			job_pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (row_end_s1) begin
			job_data_q.accum <= base_acc + term;
			job_data_q.rnorm <= base_rn + vsq;
			job_data_q.qnorm <= qnorm_q;
			job_data_q.mode <= mode_s1;
			job_data_q.last_row <= lrow_s1;
		end
	end

	assign job_valid = job_pend_q;
	assign restart = v_s1 && q_s1 && end_s1;
	assign job = job_data_q;
endmodule

// ===== hdl/nnmm_back.sv =====
`timescale 1ns / 1ps
module nnmm_back #(
	parameter int MAX_ROWS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  nnmm_pkg::row_job_t job,
	input  logic restart,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [nnmm_pkg::ScoreW-1:0] score,
	output logic [nnmm_pkg::IdxW-1:0] row_index,
	output logic [nnmm_pkg::IdxW-1:0] best_index,
	output logic is_final
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001, ST_MUL = 6'b000010, ST_ROOT = 6'b000100,
		ST_DIV = 6'b001000, ST_CMP = 6'b010000, ST_OUT = 6'b100000
	} state_t;

	localparam int DW = nnmm_pkg::ScoreW + 16;
	localparam int HW = nnmm_pkg::NormW / 2;

	state_t state_q;
	nnmm_pkg::row_job_t job_q;
	logic [nnmm_pkg::ProdW-1:0] prod_q, rem_q;
	logic [nnmm_pkg::RootW-1:0] root_q;
	logic [6:0] step_q;
	logic [DW-1:0] num_q, quo_q;
	logic [DW:0] drem_q;
	logic signed [nnmm_pkg::ScoreW-1:0] score_q, best_q;
	logic [nnmm_pkg::IdxW-1:0] row_q, best_row_q;
	logic pend_restart_q;
	logic neg_q;

	logic [nnmm_pkg::ProdW+1:0] trial;
	logic [nnmm_pkg::ProdW+1:0] rem_sh;
	logic [DW:0] dsh;
	logic better;
	logic [nnmm_pkg::ScoreW:0] mag;
	logic [HW-1:0] ma, mb;
	logic [nnmm_pkg::NormW-1:0] mpart;
	logic [6:0] mshift;

	assign job_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// The norm product is built from four half-width partial products.
	assign ma = step_q[1] ? job_q.qnorm[nnmm_pkg::NormW-1:HW] : job_q.qnorm[HW-1:0];
	assign mb = step_q[0] ? job_q.rnorm[nnmm_pkg::NormW-1:HW] : job_q.rnorm[HW-1:0];
	assign mpart = {{HW{1'b0}}, ma} * {{HW{1'b0}}, mb};
	assign mshift = (step_q[1] ? 7'(HW) : 7'd0) + (step_q[0] ? 7'(HW) : 7'd0);

	// Restoring square root, one result bit per cycle.
	assign rem_sh = {rem_q, prod_q[nnmm_pkg::ProdW-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign dsh = {drem_q[DW-1:0], num_q[DW-1]};
	assign mag = job_q.accum[nnmm_pkg::ScoreW-1] ? -{job_q.accum[nnmm_pkg::ScoreW-1],
		job_q.accum} : {1'b0, job_q.accum};

	always_comb begin
		if (row_q == '0) begin
			better = 1'b1;
		end else if (job_q.mode == nnmm_pkg::MODE_COS) begin
			better = score_q > best_q;
		end else begin
			better = score_q < best_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					job_q <= job;
					score_q <= job.accum;
					prod_q <= '0;
					step_q <= 7'd0;
				end
			end
			ST_MUL: begin
				prod_q <= prod_q + (nnmm_pkg::ProdW'(mpart) << mshift);
				rem_q <= '0;
				root_q <= '0;
				step_q <= (step_q == 7'd3) ? 7'(nnmm_pkg::ProdW / 2) : step_q + 7'd1;
				neg_q <= job_q.accum[nnmm_pkg::ScoreW-1];
				num_q <= {mag[nnmm_pkg::ScoreW-1:0], 16'h0};
			end
			ST_ROOT: begin
				prod_q <= prod_q << 2;
				if (rem_sh >= trial) begin
					rem_q <= nnmm_pkg::ProdW'(rem_sh - trial);
					root_q <= {root_q[nnmm_pkg::RootW-2:0], 1'b1};
				end else begin
					rem_q <= nnmm_pkg::ProdW'(rem_sh);
					root_q <= {root_q[nnmm_pkg::RootW-2:0], 1'b0};
				end
				step_q <= (step_q == 7'd1) ? 7'(DW) : step_q - 7'd1;
				drem_q <= '0;
			end
			ST_DIV: begin
				num_q <= num_q << 1;
				if (dsh >= (DW+1)'(root_q)) begin
					drem_q <= dsh - (DW+1)'(root_q);
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					drem_q <= dsh;
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
				step_q <= step_q - 7'd1;
			end
			ST_CMP: begin
			end
			default: begin
			end
		endcase
		if (state_q == ST_DIV && step_q == 7'd1) begin
			if (root_q == '0) begin
				score_q <= '0;
			end else if ({quo_q[DW-2:0], !(dsh < (DW+1)'(root_q))} >
				DW'(nnmm_pkg::MAX_SCORE)) begin
				score_q <= neg_q ? -nnmm_pkg::MAX_SCORE : nnmm_pkg::MAX_SCORE;
			end else begin
				score_q <= neg_q ? -nnmm_pkg::ScoreW'({quo_q[DW-2:0], !(dsh < (DW+1)'(root_q))})
					: nnmm_pkg::ScoreW'({quo_q[DW-2:0], !(dsh < (DW+1)'(root_q))});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			best_row_q <= '0;
			best_q <= '0;
			pend_restart_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && job_valid) begin
				pend_restart_q <= 1'b0;
			end else if (restart) begin
				pend_restart_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (pend_restart_q || restart) begin
							row_q <= '0;
						end
						state_q <= (job.mode == nnmm_pkg::MODE_COS) ? ST_MUL : ST_CMP;
					end
				end
				ST_MUL: if (step_q == 7'd3) state_q <= ST_ROOT;
				ST_ROOT: if (step_q == 7'd1) state_q <= ST_DIV;
				ST_DIV: if (step_q == 7'd1) state_q <= ST_CMP;
				ST_CMP: begin
					if (better) begin
						best_q <= score_q;
						best_row_q <= row_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
						if (job_q.last_row) begin
							row_q <= '0;
						end else if (32'(row_q) < MAX_ROWS - 1) begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A zero norm gives a zero cosine score before the compare.
	always_comb begin
		score = score_q;
		row_index = row_q;
		best_index = best_row_q;
		is_final = job_q.last_row;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(score))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && job_ready |=> !job_ready) else $error("back end took two jobs");
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	localparam logic [nnmm_pkg::ModeW-1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] ADDR_METRIC = 2'd0;
	localparam int LAST_IDX = 63;
	localparam int TOP_ROW = 1023;
	localparam longint MAX41 = (64'sd1 <<< 40) - 1;

	typedef struct packed {
		logic [nnmm_pkg::ScoreW-1:0] sc;
		logic [nnmm_pkg::IdxW-1:0] ri;
		logic [nnmm_pkg::IdxW-1:0] bi;
		logic fin;
	} nn_result_t;

	typedef struct packed {
		logic signed [15:0] fv;
		logic q;
		logic le;
		logic lr;
		logic typed;
		logic [nnmm_pkg::ScoreW-1:0] val;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] feature_value = 0;
	logic is_query = 0, last_element = 0, last_row = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [40:0] score;
	logic [9:0] row_index, best_index;
	logic is_final;

	nearest_neighbor_multi_metric dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	logic signed [15:0] qvec [64];
	bit qwritten [64];
	longint qnorm, acc, rnorm, best_sc;
	int ecnt, rcnt, best_r;
	logic [nnmm_pkg::ModeW-1:0] cur_mode;
	nn_result_t pending [$];
	int errors = 0;
	int in_idle = 0, out_idle = 0;
	bit hold = 0, pressure_go = 0;
	bit typed_on = 0;
	logic [nnmm_pkg::ScoreW-1:0] typed_val;

	task automatic report(input string what, input longint got, input longint want);
		$display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic longint unsigned root_of_product(longint a, longint b);
		logic [83:0] p, c;
		logic [83:0] r;
		p = 84'(a) * 84'(b);
		r = 0;
		for (int i = 41; i >= 0; i--) begin
			c = r | (84'd1 << i);
			if (c * c <= p)
				r = c;
		end
		return r[63:0];
	endfunction

	function automatic longint cosine_q16(longint dot, longint nx, longint ny);
		longint unsigned den, mag, quo;
		if (nx <= 0 || ny <= 0)
			return 0;
		den = root_of_product(nx, ny);
		if (den == 0)
			return 0;
		mag = (dot < 0) ? -dot : dot;
		mag &= (64'd1 << 41) - 1;
		quo = (mag << 16) / den;
		if (quo > MAX41)
			quo = MAX41;
		return (dot < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic bit score_row(input logic signed [15:0] fv, input logic q,
			input logic le, input logic lr, output nn_result_t res);
		longint v, x, d, s;
		int idx;
		bit vend, better;
		v = fv;
		idx = ecnt;
		vend = le || ecnt >= LAST_IDX;
		if (q) begin
			if (idx == 0)
				qnorm = 0;
			qvec[idx] = fv;
			qwritten[idx] = 1;
			qnorm += v * v;
			ecnt = vend ? 0 : ecnt + 1;
			if (vend)
				rcnt = 0;
			return 0;
		end
		x = qvec[idx];
		d = x - v;
		if (idx == 0) begin
			acc = 0;
			rnorm = 0;
		end
		if (cur_mode == nnmm_pkg::MODE_EUC)
			acc += d * d;
		else if (cur_mode == nnmm_pkg::MODE_COS)
			acc += x * v;
		else
			acc += (d < 0) ? -d : d;
		rnorm += v * v;
		if (!vend) begin
			ecnt++;
			return 0;
		end
		ecnt = 0;
		s = (cur_mode == nnmm_pkg::MODE_COS) ? cosine_q16(acc, qnorm, rnorm) : acc;
		if (rcnt == 0)
			better = 1;
		else if (cur_mode == nnmm_pkg::MODE_COS)
			better = s > best_sc;
		else
			better = s < best_sc;
		if (better) begin
			best_sc = s;
			best_r = rcnt;
		end
		res.sc = s[nnmm_pkg::ScoreW-1:0];
		res.ri = rcnt[nnmm_pkg::IdxW-1:0];
		res.bi = best_r[nnmm_pkg::IdxW-1:0];
		res.fin = lr;
		if (lr)
			rcnt = 0;
		else if (rcnt < TOP_ROW)
			rcnt++;
		return 1;
	endfunction

	task automatic send(input logic signed [15:0] fv, input logic q, input logic le,
			input logic lr);
		nn_result_t res;
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1;
		feature_value <= fv;
		is_query <= q;
		last_element <= le;
		last_row <= lr;
		do @(posedge clk); while (!in_ready);
		if (score_row(fv, q, le, lr, res)) begin
			if (typed_on)
				res.sc = typed_val;
			pending.push_back(res);
		end
	endtask

	task automatic write_mode(input logic [nnmm_pkg::ModeW-1:0] m);
		in_valid <= 0;
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_METRIC;
		pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		cur_mode = m;
	endtask

	task automatic settle;
		in_valid <= 0;
		wait (pending.size() == 0);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_value;
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_items(input int n);
		int sent, len;
		bit lr, zero_row;
		sent = 0;
		while (sent < n) begin
			if (ecnt == 0 && $urandom_range(99) < 6) begin
				len = ($urandom_range(3) == 0) ? 64 : $urandom_range(1, 12);
				lr = ($urandom_range(1) != 0);
				for (int i = 0; i < len; i++) begin
					send(pick_value(), 1, i == len - 1, lr && ($urandom_range(1) != 0));
					sent++;
				end
				continue;
			end
			len = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 64);
			lr = ($urandom_range(5) == 0);
			zero_row = ($urandom_range(19) == 0);
			for (int i = 0; i < len; i++) begin
				bit le;
				if ($urandom_range(99) < 3 || !qwritten[ecnt]) begin
					send(pick_value(), 1, 0, $urandom_range(1) != 0);
					sent++;
					if (ecnt == 0)
						break;
				end
				le = (i == len - 1) || ecnt == LAST_IDX || !qwritten[ecnt + 1];
				if (ecnt == LAST_IDX)
					le = ($urandom_range(1) != 0);
				send(zero_row ? 16'sd0 : pick_value(), 0, le, lr);
				sent++;
				if (ecnt == 0)
					break;
			end
		end
	endtask

	stim_row_t plan [] = '{
		'{16'sd32767, 1, 0, 0, 0, 0}, '{-16'sd32768, 1, 0, 1, 0, 0},
		'{16'sd0, 1, 0, 0, 0, 0}, '{16'sd1, 1, 1, 1, 0, 0},
		'{-16'sd32768, 0, 0, 0, 0, 0}, '{16'sd32767, 0, 0, 0, 0, 0},
		'{16'sd0, 0, 0, 0, 0, 0}, '{16'sd1, 0, 1, 0, 1, 41'd131070},
		'{16'sd32767, 0, 0, 0, 0, 0}, '{-16'sd32768, 0, 0, 0, 0, 0},
		'{16'sd0, 0, 0, 0, 0, 0}, '{16'sd1, 0, 1, 0, 1, 41'd0},
		'{16'sd32767, 0, 0, 0, 0, 0}, '{-16'sd32768, 0, 0, 0, 0, 0},
		'{16'sd0, 0, 0, 0, 0, 0}, '{16'sd1, 0, 1, 0, 1, 41'd0},
		'{16'sd32767, 0, 1, 1, 1, 41'd0},
		'{16'sd7, 0, 0, 0, 0, 0}, '{16'sd5, 1, 0, 1, 0, 0}, '{-16'sd3, 0, 1, 0, 0, 0}
	};

	initial begin
		qnorm = 0;
		acc = 0;
		rnorm = 0;
		best_sc = 0;
		ecnt = 0;
		rcnt = 0;
		best_r = 0;
		cur_mode = nnmm_pkg::MODE_MAN;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (plan[i]) begin
			typed_on = plan[i].typed;
			typed_val = plan[i].val;
			send(plan[i].fv, plan[i].q, plan[i].le, plan[i].lr);
		end
		typed_on = 0;
		settle();
		for (int i = 0; i < 64; i++)
			send(pick_value(), 1, i == 63, 0);
		in_idle = 8;
		out_idle = 88;
		write_mode(nnmm_pkg::MODE_EUC);
		random_items(200);
		settle();
		in_idle = 88;
		out_idle = 8;
		write_mode(nnmm_pkg::MODE_COS);
		random_items(200);
		settle();
		in_idle = 0;
		out_idle = 0;
		write_mode(MODE_SPARE);
		pressure_go = 1;
		random_items(250);
		settle();
		write_mode(nnmm_pkg::MODE_MAN);
		for (int i = 0; i < 1030; i++)
			send(pick_value(), 0, 1, i == 1029);
		settle();
		write_mode(nnmm_pkg::MODE_COS);
		random_items(70);
		settle();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		wait (pressure_go);
		hold = 1;
		repeat (300) @(posedge clk);
		hold = 0;
	end

	initial begin
		nn_result_t want;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending.size() == 0) begin
					report("unexpected item, row_index", row_index, 0);
				end else begin
					want = pending.pop_front();
					if (score !== want.sc)
						report("score", score, $signed(want.sc));
					if (row_index !== want.ri)
						report("row_index", row_index, want.ri);
					if (best_index !== want.bi)
						report("best_index", best_index, want.bi);
					if (is_final !== want.fin)
						report("is_final", is_final, want.fin);
				end
			end
			out_ready <= hold ? 1'b0 : ($urandom_range(99) >= out_idle);
		end
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/nnmm_pkg.sv
hdl/nnmm_ram.sv
hdl/nnmm_front.sv
hdl/nnmm_back.sv
hdl/nearest_neighbor_multi_metric.sv
tb/sv/tb.sv
